// ===== hdl/ivf_pkg.sv =====
package ivf_pkg;

  localparam int SENSOR_COUNT = 3;
  localparam int NUM_CHANNELS = 3;
  localparam int CH_W         = 2;
  localparam int VAL_W        = 32;
  localparam int VAR_W        = 32;
  localparam int WGT_W        = 17;
  localparam int FRAC_W       = 16;
  localparam int QUO_W        = 48;
  localparam int IDX_W        = $clog2(SENSOR_COUNT);
  localparam int DIV_W        = QUO_W + $clog2(SENSOR_COUNT);
  localparam int PROD_W       = VAL_W + WGT_W + 1;
  localparam int ACC_W        = PROD_W + $clog2(SENSOR_COUNT);
  localparam int CNT_W        = 6;

  // 2^47 / variance yields up to 48 quotient bits; a weight needs 17
  localparam logic [CNT_W-1:0] INV_STEPS = CNT_W'(QUO_W);
  localparam logic [CNT_W-1:0] WGT_STEPS = CNT_W'(WGT_W);
  localparam logic [QUO_W-1:0] INV_NUMER = QUO_W'(1) << (QUO_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INV_START,
    ST_INV_WAIT,
    ST_WGT_START,
    ST_WGT_WAIT,
    ST_MAC,
    ST_MAC_DRAIN,
    ST_DONE
  } ivf_state_e;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_req_t;

endpackage

// ===== hdl/inverse_variance_fusion.sv =====
// Inverse-variance weighted fusion of three sensor readings for one channel
// (0 x, 1 y, 2 heading) per item.
// Input channel: in_valid_i/in_ready_o with channel, readings, variances and
// enables. Output channel: out_valid_o/out_ready_i with the fused value,
// channel, weights_updated and result_valid flags.
// Both divides share one radix-2 divider, one quotient bit per cycle. Each
// enabled sensor gets a 2^47/variance divide (a disabled one is skipped),
// then each sensor with a nonzero inverse gets a normalizing divide (a zero
// one is skipped, and all are when no sensor is enabled), then come the
// multiply-accumulate and the output load.
// Zero variance on an enabled sensor, or channel 3, skips the divides and
// goes straight to the done state. in_ready_o is high only while the
// sequencer is idle; one item is worked on at a time.
// The result sits in an output register; a new item may be accepted while it
// waits, but the next result is held back until the previous transfer.
// Reset clears the per-channel weights and last outputs to zero and empties
// the output register.
module inverse_variance_fusion (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ivf_pkg::CH_W-1:0]     channel_i,
  input  logic signed [ivf_pkg::VAL_W-1:0] value_a_i,
  input  logic signed [ivf_pkg::VAL_W-1:0] value_b_i,
  input  logic signed [ivf_pkg::VAL_W-1:0] value_c_i,
  input  logic [ivf_pkg::VAR_W-1:0]    variance_a_i,
  input  logic [ivf_pkg::VAR_W-1:0]    variance_b_i,
  input  logic [ivf_pkg::VAR_W-1:0]    variance_c_i,
  input  logic                         enable_a_i,
  input  logic                         enable_b_i,
  input  logic                         enable_c_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [ivf_pkg::VAL_W-1:0] fused_value_o,
  output logic [ivf_pkg::CH_W-1:0]     out_channel_o,
  output logic                         weights_updated_o,
  output logic                         result_valid_o
);
  import ivf_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);
  localparam int SH_W = ACC_W + 1 - FRAC_W;
  localparam logic signed [SH_W-1:0] MAX_V = {{(SH_W-VAL_W){1'b0}}, 1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [SH_W-1:0] MIN_V = {{(SH_W-VAL_W){1'b1}}, 1'b1, {(VAL_W-1){1'b0}}};

  ivf_state_e state_q, state_d;

  logic signed [VAL_W-1:0] val_in [SENSOR_COUNT];
  logic [VAR_W-1:0]        var_in [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] en_in;
  logic                    zero_var;
  logic                    in_xfer;
  logic                    ch_ok_in;

  logic signed [VAL_W-1:0] val_q [SENSOR_COUNT];
  logic [VAR_W-1:0]        var_q [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] en_q;
  logic [CH_W-1:0]         ch_q;
  logic                    ok_q;
  logic                    upd_q;
  logic [IDX_W-1:0]        idx_q;
  logic [QUO_W-1:0]        inv_q [SENSOR_COUNT];
  logic [DIV_W-1:0]        sum_q;

  logic [WGT_W-1:0]        wstore_q [NUM_CHANNELS][SENSOR_COUNT];
  logic signed [VAL_W-1:0] last_q [NUM_CHANNELS];

  div_req_t                div_req;
  logic [DIV_W-1:0]        div_rem;
  logic [QUO_W-1:0]        div_bits;
  logic [DIV_W-1:0]        div_dsr;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;

  logic                    mac_en;
  logic signed [ACC_W-1:0] acc;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] fused_q;
  logic [CH_W-1:0]         och_q;
  logic                    oupd_q;
  logic                    ook_q;
  logic                    out_load;

  logic signed [ACC_W:0]   rnd;
  logic signed [SH_W-1:0]  shr;
  logic signed [VAL_W-1:0] sat;
  logic signed [VAL_W-1:0] fused_sel;

  assign val_in = '{value_a_i, value_b_i, value_c_i};
  assign var_in = '{variance_a_i, variance_b_i, variance_c_i};
  assign en_in  = {enable_c_i, enable_b_i, enable_a_i};

  always_comb begin
    zero_var = 1'b0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      zero_var = zero_var | (en_in[i] & (var_in[i] == '0));
    end
  end

  assign ch_ok_in   = (channel_i < CH_W'(NUM_CHANNELS));
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_load   = (state_q == ST_DONE) & (~out_valid_q | out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (ch_ok_in && !zero_var) ? ST_INV_START : ST_DONE;
        end
      end
      ST_INV_START: begin
        if (en_q[idx_q]) begin
          state_d = ST_INV_WAIT;
        end else if (idx_q == LAST_IDX) begin
          state_d = ST_WGT_START;
        end
      end
      ST_INV_WAIT: begin
        if (div_done) begin
          state_d = (idx_q == LAST_IDX) ? ST_WGT_START : ST_INV_START;
        end
      end
      ST_WGT_START: begin
        if (sum_q == '0) begin
          state_d = ST_MAC;
        end else if (inv_q[idx_q] != '0) begin
          state_d = ST_WGT_WAIT;
        end else if (idx_q == LAST_IDX) begin
          state_d = ST_MAC;
        end
      end
      ST_WGT_WAIT: begin
        if (div_done) begin
          state_d = (idx_q == LAST_IDX) ? ST_MAC : ST_WGT_START;
        end
      end
      ST_MAC: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_MAC_DRAIN;
        end
      end
      ST_MAC_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_req  = '0;
    div_rem  = '0;
    div_bits = INV_NUMER;
    div_dsr  = DIV_W'(var_q[idx_q]);
    mac_en   = 1'b0;
    unique case (state_q)
      ST_INV_START: begin
        div_req.start = en_q[idx_q];
        div_req.steps = INV_STEPS;
      end
      ST_WGT_START: begin
        div_req.start = (sum_q != '0) && (inv_q[idx_q] != '0);
        div_req.steps = WGT_STEPS;
        // numerator inv << 16: high part preloads the remainder
        div_rem       = DIV_W'(inv_q[idx_q][QUO_W-1:1]);
        div_bits      = {inv_q[idx_q][0], {(QUO_W-1){1'b0}}};
        div_dsr       = sum_q;
      end
      ST_MAC: mac_en = 1'b1;
      default: ;
    endcase
  end

  ivf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .rem_init_i (div_rem),
    .bits_i     (div_bits),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  ivf_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (in_xfer),
    .en_i     (mac_en),
    .value_i  (val_q[idx_q]),
    .weight_i (wstore_q[ch_q][idx_q]),
    .acc_o    (acc)
  );

  // round half up, then saturate
  assign rnd = ACC_W'(acc) + (ACC_W+1)'(1 << (FRAC_W - 1));
  assign shr = rnd[ACC_W:FRAC_W];

  always_comb begin
    if (shr > MAX_V) begin
      sat = MAX_V[VAL_W-1:0];
    end else if (shr < MIN_V) begin
      sat = MIN_V[VAL_W-1:0];
    end else begin
      sat = shr[VAL_W-1:0];
    end
  end

  always_comb begin
    if (ok_q) begin
      fused_sel = sat;
    end else if (ch_q < CH_W'(NUM_CHANNELS)) begin
      fused_sel = last_q[ch_q];
    end else begin
      fused_sel = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      wstore_q    <= '{default: '{default: '0}};
      last_q      <= '{default: '0};
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
      priority if (in_xfer) begin
        idx_q <= '0;
      end else if (state_q != state_d &&
                   (state_d == ST_WGT_START || state_d == ST_MAC) &&
                   (state_q == ST_INV_START || state_q == ST_INV_WAIT ||
                    state_q == ST_WGT_START || state_q == ST_WGT_WAIT) &&
                   (idx_q == LAST_IDX || sum_q == '0 ||
                    state_q == ST_INV_START || state_q == ST_INV_WAIT) &&
                   !(state_q == ST_WGT_WAIT && state_d == ST_WGT_START)) begin
        // phase change
        idx_q <= (state_d == ST_MAC && state_q == ST_WGT_START && sum_q != '0 &&
                  idx_q != LAST_IDX) ? idx_q + IDX_W'(1) : '0;
      end else if ((state_q == ST_INV_START && !en_q[idx_q]) ||
                   (state_q == ST_INV_WAIT && div_done) ||
                   (state_q == ST_WGT_START && sum_q != '0 && inv_q[idx_q] == '0) ||
                   (state_q == ST_WGT_WAIT && div_done) ||
                   (state_q == ST_MAC)) begin
        idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
      end
      if (state_q == ST_WGT_START && sum_q != '0 && inv_q[idx_q] == '0) begin
        wstore_q[ch_q][idx_q] <= '0;
      end
      if (state_q == ST_WGT_WAIT && div_done) begin
        wstore_q[ch_q][idx_q] <= div_quo[WGT_W-1:0];
      end
      if (out_load && ok_q) begin
        last_q[ch_q] <= sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      val_q <= val_in;
      var_q <= var_in;
      en_q  <= en_in;
      ch_q  <= channel_i;
      ok_q  <= ch_ok_in & ~zero_var;
      upd_q <= 1'b0;
      sum_q <= '0;
    end
    if (state_q == ST_INV_START && !en_q[idx_q]) begin
      inv_q[idx_q] <= '0;
    end
    if (state_q == ST_INV_WAIT && div_done) begin
      inv_q[idx_q] <= div_quo;
      sum_q        <= sum_q + DIV_W'(div_quo);
    end
    if (state_q == ST_WGT_START && sum_q != '0) begin
      upd_q <= 1'b1;
    end
    if (out_load) begin
      fused_q <= fused_sel;
      och_q   <= ch_q;
      oupd_q  <= upd_q;
      ook_q   <= ok_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign fused_value_o     = fused_q;
  assign out_channel_o     = och_q;
  assign weights_updated_o = oupd_q;
  assign result_valid_o    = ook_q;

endmodule

// ===== hdl/ivf_div.sv =====
module ivf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ivf_pkg::div_req_t         req_i,
  input  logic [ivf_pkg::DIV_W-1:0] rem_init_i,
  input  logic [ivf_pkg::QUO_W-1:0] bits_i,
  input  logic [ivf_pkg::DIV_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ivf_pkg::QUO_W-1:0] quotient_o
);
  import ivf_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dsr_q, dsr_d;
  logic [QUO_W-1:0] bits_q, bits_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             ge;

  // restoring divider, one quotient bit per cycle
  assign shifted = {rem_q, bits_q[QUO_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = ~diff[DIV_W];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    bits_d = bits_q;
    quo_d  = quo_q;
    done_d = busy_q && (cnt_q == CNT_W'(1));
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = rem_init_i;
      dsr_d  = divisor_i;
      bits_d = bits_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      bits_d = {bits_q[QUO_W-2:0], 1'b0};
      quo_d  = {quo_q[QUO_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    bits_q <= bits_d;
    quo_q  <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/ivf_mac.sv =====
module ivf_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic                             en_i,
  input  logic signed [ivf_pkg::VAL_W-1:0] value_i,
  input  logic        [ivf_pkg::WGT_W-1:0] weight_i,
  output logic signed [ivf_pkg::ACC_W-1:0] acc_o
);
  import ivf_pkg::*;

  logic                     pv_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(value_i) * PROD_W'($signed({1'b0, weight_i}));
    if (clear_i) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== dv/tb.sv =====
module tb;
  import ivf_pkg::*;

  localparam logic [CH_W-1:0] CH_X       = 2'd0;
  localparam logic [CH_W-1:0] CH_Y       = 2'd1;
  localparam logic [CH_W-1:0] CH_HEADING = 2'd2;
  localparam logic [CH_W-1:0] CH_UNUSED  = 2'd3;

  localparam int RANDOM_ITEMS = 1332;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAR_W-1:0] VAR_ONE = 32'h0001_0000;
  localparam logic [VAR_W-1:0] VAR_MAX = 32'hffff_ffff;

  typedef struct packed {
    logic [CH_W-1:0]                    channel;
    logic [SENSOR_COUNT-1:0][VAL_W-1:0] value;
    logic [SENSOR_COUNT-1:0][VAR_W-1:0] variance;
    logic [SENSOR_COUNT-1:0]            enable;
  } fusion_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CH_W-1:0]  channel;
    logic             updated;
    logic             ok;
  } fusion_res_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [CH_W-1:0]         channel_i    = '0;
  logic signed [VAL_W-1:0] value_a_i    = '0;
  logic signed [VAL_W-1:0] value_b_i    = '0;
  logic signed [VAL_W-1:0] value_c_i    = '0;
  logic [VAR_W-1:0]        variance_a_i = '0;
  logic [VAR_W-1:0]        variance_b_i = '0;
  logic [VAR_W-1:0]        variance_c_i = '0;
  logic                    enable_a_i   = 1'b0;
  logic                    enable_b_i   = 1'b0;
  logic                    enable_c_i   = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic signed [VAL_W-1:0] fused_value_o;
  logic [CH_W-1:0]         out_channel_o;
  logic                    weights_updated_o;
  logic                    result_valid_o;

  inverse_variance_fusion i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .channel_i         (channel_i),
    .value_a_i         (value_a_i),
    .value_b_i         (value_b_i),
    .value_c_i         (value_c_i),
    .variance_a_i      (variance_a_i),
    .variance_b_i      (variance_b_i),
    .variance_c_i      (variance_c_i),
    .enable_a_i        (enable_a_i),
    .enable_b_i        (enable_b_i),
    .enable_c_i        (enable_c_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .fused_value_o     (fused_value_o),
    .out_channel_o     (out_channel_o),
    .weights_updated_o (weights_updated_o),
    .result_valid_o    (result_valid_o)
  );

  fusion_item_t     pending_items[$];
  fusion_res_t      fused_expect[$];
  fusion_item_t     cur_item;
  logic [WGT_W-1:0] weight_mem [NUM_CHANNELS*SENSOR_COUNT];
  logic [VAL_W-1:0] last_fused [NUM_CHANNELS];

  int total_items   = 0;
  int accepted      = 0;
  int results_seen  = 0;
  int errors        = 0;
  int held_count    = 0;
  int reused_count  = 0;
  int unused_count  = 0;
  int tx_idle_pct   = 28;
  int rx_idle_pct   = 69;
  int quiet_cycles  = 0;

  function automatic fusion_item_t mk_item(logic [CH_W-1:0] ch, logic [VAL_W-1:0] va,
                                           logic [VAL_W-1:0] vb, logic [VAL_W-1:0] vc,
                                           logic [VAR_W-1:0] sa, logic [VAR_W-1:0] sb,
                                           logic [VAR_W-1:0] sc, logic [2:0] en);
    fusion_item_t it;
    it.channel     = ch;
    it.value[0]    = va;
    it.value[1]    = vb;
    it.value[2]    = vc;
    it.variance[0] = sa;
    it.variance[1] = sb;
    it.variance[2] = sc;
    it.enable      = en;
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return VAL_MAX;
    if (pick < 10) return VAL_MIN;
    if (pick < 30) return VAL_W'($signed($urandom_range(65535)) - 32768) <<< 8;
    return $urandom;
  endfunction

  function automatic logic [VAR_W-1:0] rand_variance();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 10) return VAR_MAX;
    if (pick < 25) return $urandom_range(255, 1);
    if (pick < 55) return $urandom & 32'h000f_ffff;
    return $urandom;
  endfunction

  function automatic fusion_item_t rand_item();
    fusion_item_t it;
    it.channel = ($urandom_range(99) < 5) ? CH_UNUSED : CH_W'($urandom_range(2));
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      it.value[i]    = rand_value();
      it.variance[i] = rand_variance();
    end
    it.enable = SENSOR_COUNT'($urandom);
    return it;
  endfunction

  function automatic fusion_res_t fuse_predict(fusion_item_t it);
    fusion_res_t r;
    logic [63:0] inv [SENSOR_COUNT];
    logic [63:0] inv_sum;
    bit          bad_var;
    longint      acc;
    longint      q;
    int          base;
    r.value   = '0;
    r.channel = it.channel;
    r.updated = 1'b0;
    r.ok      = 1'b0;
    if (it.channel >= NUM_CHANNELS) return r;
    inv_sum = '0;
    bad_var = 1'b0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      inv[i] = '0;
      if (it.enable[i]) begin
        if (it.variance[i] == '0) bad_var = 1'b1;
        else inv[i] = (64'd1 << 47) / {32'd0, it.variance[i]};
      end
      inv_sum += inv[i];
    end
    if (bad_var) begin
      r.value = last_fused[it.channel];
      return r;
    end
    base = int'(it.channel) * SENSOR_COUNT;
    if (inv_sum != '0) begin
      for (int i = 0; i < SENSOR_COUNT; i++)
        weight_mem[base+i] = WGT_W'((inv[i] << FRAC_W) / inv_sum);
      r.updated = 1'b1;
    end
    acc = 0;
    for (int i = 0; i < SENSOR_COUNT; i++)
      acc += longint'($signed(it.value[i])) * longint'(weight_mem[base+i]);
    q = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    if (q > longint'(32'sh7fff_ffff)) q = longint'(32'sh7fff_ffff);
    if (q < -longint'(64'h8000_0000)) q = -longint'(64'h8000_0000);
    last_fused[it.channel] = q[VAL_W-1:0];
    r.value = q[VAL_W-1:0];
    r.ok    = 1'b1;
    return r;
  endfunction

  task automatic report_error(string msg);
    if (errors < 10) $display("mismatch: %s", msg);
    errors++;
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : drive_blk
    fusion_res_t want;
    bit          slot_free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      slot_free = !in_valid_i || in_ready_o;
      if (in_valid_i && in_ready_o) begin
        want = fuse_predict(cur_item);
        fused_expect.push_back(want);
        accepted++;
        if (cur_item.channel == CH_UNUSED) unused_count++;
        else if (!want.ok) held_count++;
        else if (!want.updated) reused_count++;
        if (accepted * 3 >= 2 * total_items) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end else if (accepted * 3 >= total_items) begin
          tx_idle_pct = 69;
          rx_idle_pct = 28;
        end
      end
      if (slot_free) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_item = pending_items.pop_front();
          channel_i    <= cur_item.channel;
          value_a_i    <= cur_item.value[0];
          value_b_i    <= cur_item.value[1];
          value_c_i    <= cur_item.value[2];
          variance_a_i <= cur_item.variance[0];
          variance_b_i <= cur_item.variance[1];
          variance_c_i <= cur_item.variance[2];
          enable_a_i   <= cur_item.enable[0];
          enable_b_i   <= cur_item.enable[1];
          enable_c_i   <= cur_item.enable[2];
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor_blk
    fusion_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (fused_expect.size() == 0) begin
          report_error($sformatf("unexpected transfer value=%h ch=%0d upd=%b ok=%b",
                                 fused_value_o, out_channel_o, weights_updated_o,
                                 result_valid_o));
        end else begin
          want = fused_expect.pop_front();
          if (fused_value_o !== want.value || out_channel_o !== want.channel ||
              weights_updated_o !== want.updated || result_valid_o !== want.ok)
            report_error($sformatf(
              "#%0d exp value=%h ch=%0d upd=%b ok=%b, got value=%h ch=%0d upd=%b ok=%b",
              results_seen, want.value, want.channel, want.updated, want.ok,
              fused_value_o, out_channel_o, weights_updated_o, result_valid_o));
        end
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NUM_CHANNELS * SENSOR_COUNT; i++) weight_mem[i] = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) last_fused[i] = '0;

    // stored weights still zero, then equal weights, then reuse
    pending_items.push_back(mk_item(CH_X, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                    VAR_ONE, VAR_ONE, VAR_ONE, 3'b000));
    pending_items.push_back(mk_item(CH_X, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                    VAR_ONE, VAR_ONE, VAR_ONE, 3'b111));
    pending_items.push_back(mk_item(CH_X, VAL_MAX, VAL_MAX, VAL_MAX,
                                    '0, '0, '0, 3'b000));
    pending_items.push_back(mk_item(CH_Y, VAL_MAX, 32'h0, 32'h0,
                                    32'd1, '0, '0, 3'b001));
    pending_items.push_back(mk_item(CH_Y, 32'h0, VAL_MIN, 32'h0,
                                    '0, VAR_MAX, '0, 3'b010));
    pending_items.push_back(mk_item(CH_Y, 32'h0, 32'h0, VAL_MIN,
                                    '0, '0, VAR_MAX, 3'b100));
    pending_items.push_back(mk_item(CH_HEADING, VAL_MAX, VAL_MIN, 32'hffff_ffff,
                                    32'd1, VAR_MAX, 32'h8000_0000, 3'b111));
    // zero variance on an enabled sensor holds the last output
    pending_items.push_back(mk_item(CH_HEADING, 32'h1234_5678, 32'h0, 32'h0,
                                    '0, VAR_ONE, VAR_ONE, 3'b111));
    // zero variance on a disabled sensor is ignored
    pending_items.push_back(mk_item(CH_HEADING, 32'h0004_0000, VAL_MAX, 32'hfffc_0000,
                                    VAR_ONE, '0, 32'h0004_0000, 3'b101));
    pending_items.push_back(mk_item(CH_UNUSED, 32'h1111_1111, 32'h2222_2222,
                                    32'h3333_3333, VAR_ONE, '0, VAR_MAX, 3'b011));
    pending_items.push_back(mk_item(CH_X, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000,
                                    VAR_ONE, VAR_ONE, '0, 3'b100));
    pending_items.push_back(mk_item(CH_X, VAL_MIN, VAL_MIN, VAL_MIN,
                                    32'd1, 32'd1, 32'd1, 3'b111));
    pending_items.push_back(mk_item(CH_Y, VAL_MAX, VAL_MAX, VAL_MAX,
                                    32'd1, 32'd2, 32'd3, 3'b111));
    pending_items.push_back(mk_item(CH_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                    VAR_MAX, VAR_MAX, VAR_MAX, 3'b111));
    pending_items.push_back(mk_item(CH_HEADING, VAL_MIN, VAL_MAX, 32'h0,
                                    VAR_MAX, VAR_MAX, VAR_MAX, 3'b000));
    pending_items.push_back(mk_item(CH_X, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                    '0, '0, '0, 3'b111));
    pending_items.push_back(mk_item(CH_Y, VAL_MAX, VAL_MIN, 32'h0,
                                    VAR_MAX, VAR_MAX, '0, 3'b011));
    pending_items.push_back(mk_item(CH_X, 32'h0, 32'h0, 32'h0,
                                    32'd1, 32'd1, 32'd1, 3'b111));

    for (int n = 0; n < RANDOM_ITEMS; n++) pending_items.push_back(rand_item());
    total_items = pending_items.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one result per item; the watchdog catches a missing one
    while (results_seen < total_items)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fused_expect.size() != 0)
      report_error($sformatf("%0d results never arrived", fused_expect.size()));

    $display("ran %0d items over all channels, %0d results checked", accepted,
             results_seen);
    $display("%0d held on zero variance, %0d on stored weights, %0d on channel 3, %0d errors",
             held_count, reused_count, unused_count, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
